// ----- src/pgd_pkg.sv -----
// shared types, constants and table functions for the psk gray hard demapper
package pgd_pkg;

   localparam int TABLE_BITS       = 6;
   localparam int MAX_BITS_DEFAULT = 6;
   localparam int SAMPLE_W         = 16;
   localparam int INDEX_W          = TABLE_BITS;
   localparam int NB_W             = 3;
   localparam logic [NB_W-1:0] BPS_RESET = 3'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_i;
      logic signed [SAMPLE_W-1:0] sample_q;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] decided_bits;
      logic [INDEX_W-1:0] point_index;
   } rsp_type;

   // round(16384*cos(pi*r/32)), r = 0..16
   function automatic logic [14:0] quarter_cos(logic [4:0] r);
      logic [14:0] v;
      case (r)
         5'd0:    v = 15'd16384;
         5'd1:    v = 15'd16305;
         5'd2:    v = 15'd16069;
         5'd3:    v = 15'd15679;
         5'd4:    v = 15'd15137;
         5'd5:    v = 15'd14449;
         5'd6:    v = 15'd13623;
         5'd7:    v = 15'd12665;
         5'd8:    v = 15'd11585;
         5'd9:    v = 15'd10394;
         5'd10:   v = 15'd9102;
         5'd11:   v = 15'd7723;
         5'd12:   v = 15'd6270;
         5'd13:   v = 15'd4756;
         5'd14:   v = 15'd3196;
         5'd15:   v = 15'd1606;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

   // full-circle cosine in q1.14 from the quarter wave
   function automatic logic signed [15:0] table_cos(logic [TABLE_BITS-1:0] a);
      logic [1:0]         quad;
      logic [4:0]         r;
      logic [4:0]         rr;
      logic signed [15:0] pos_r;
      logic signed [15:0] pos_rr;
      logic signed [15:0] v;
      quad   = a[5:4];
      r      = {1'b0, a[3:0]};
      rr     = 5'd16 - r;
      pos_r  = signed'({1'b0, quarter_cos(r)});
      pos_rr = signed'({1'b0, quarter_cos(rr)});
      case (quad)
         2'd0:    v = pos_r;
         2'd1:    v = -pos_rr;
         2'd2:    v = -pos_r;
         default: v = pos_rr;
      endcase
      return v;
   endfunction

   function automatic logic [INDEX_W-1:0] gray_to_bin(logic [INDEX_W-1:0] g);
      logic [INDEX_W-1:0] b;
      b[INDEX_W-1] = g[INDEX_W-1];
      for (int i = INDEX_W - 2; i >= 0; i--) begin
         b[i] = b[i+1] ^ g[i];
      end
      return b;
   endfunction

endpackage

// ----- src/psk_gray_hard_demapper.sv -----
// m-psk hard decision demapper with gray decoding, top level
//
//  channel  | direction | handshake                       | payload
//  req_     | in        | req_valid / req_stall           | pgd_pkg::req_type
//  rsp_     | out       | rsp_valid / rsp_stall           | pgd_pkg::rsp_type
//  csr_     | in        | csr_write_enable, no wait       | bits_per_symbol, 3 bits
//
// a beat makes one table read and one distance compare per point: each point passes through the cosine rom,
// the squared-distance register and the running minimum, then the result is loaded into the output register.
// a new beat is taken as soon as the previous result sits in the output register.
// reset is synchronous and clears control state only; the rom needs no clearing.
// rsp_stall holds the output register; the result load waits only while that register is full and stalled.
module psk_gray_hard_demapper #(
   parameter int MAX_BITS = pgd_pkg::MAX_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pgd_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pgd_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_enable,
   input  logic [pgd_pkg::NB_W-1:0]      csr_write_data
);
   import pgd_pkg::*;

   localparam int LimBits = (MAX_BITS < TABLE_BITS) ? MAX_BITS : TABLE_BITS;
   localparam logic [NB_W-1:0] LIM_NB = NB_W'(LimBits);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [NB_W-1:0]        bps_ff;
   logic [1:0]             state_ff, state_in;
   logic signed [16:0]     xi_ff, xq_ff;
   logic [NB_W-1:0]        shift_ff;
   logic [INDEX_W-1:0]     mask_ff;
   logic [INDEX_W-1:0]     k_ff, k_in;

   logic [NB_W-1:0]        nb_eff;
   logic [INDEX_W-1:0]     addr_i, addr_q;
   logic                   issue, issue_last;
   logic                   accept;

   logic signed [15:0]     cos_rd_ff, sin_rd_ff;
   logic                   s1_valid_ff;
   logic                   s1_last_ff;
   logic [INDEX_W-1:0]     s1_k_ff;

   logic signed [17:0]     di, dq;
   logic signed [35:0]     prod_i, prod_q;
   logic [32:0]            sq_i_ff, sq_q_ff;
   logic                   s2_valid_ff;
   logic                   s2_last_ff;
   logic [INDEX_W-1:0]     s2_k_ff;

   logic [33:0]            dist_sum;
   logic                   better;
   logic [33:0]            best_d_ff;
   logic [INDEX_W-1:0]     best_k_ff;

   logic                   out_free;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign issue      = (state_ff == ST_RUN);
   assign issue_last = (k_ff == mask_ff);

   always_comb begin
      if (bps_ff < 3'd1) begin
         nb_eff = 3'd1;
      end else if (bps_ff > LIM_NB) begin
         nb_eff = LIM_NB;
      end else begin
         nb_eff = bps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff <= BPS_RESET;
      end else if (csr_write_enable) begin
         bps_ff <= csr_write_data;
      end
   end

   // search sequencer
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            k_in = k_ff + INDEX_W'(1);
            if (issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s2_valid_ff && s2_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff <= k_in;
      if (accept) begin
         xi_ff    <= {req_data.sample_i, 1'b0};
         xq_ff    <= {req_data.sample_q, 1'b0};
         shift_ff <= NB_W'(TABLE_BITS) - nb_eff;
         mask_ff  <= INDEX_W'((7'd1 << nb_eff) - 7'd1);
      end
   end

   // cosine rom, two read ports, registered data
   assign addr_i = k_ff << shift_ff;
   assign addr_q = addr_i + INDEX_W'(48);

   always_ff @(posedge clock) begin
      cos_rd_ff <= table_cos(addr_i);
      sin_rd_ff <= table_cos(addr_q);
      s1_k_ff    <= k_ff;
      s1_last_ff <= issue_last;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
      end
   end

   // squared distance terms
   assign di     = 18'(xi_ff) - 18'(cos_rd_ff);
   assign dq     = 18'(xq_ff) - 18'(sin_rd_ff);
   assign prod_i = di * di;
   assign prod_q = dq * dq;

   always_ff @(posedge clock) begin
      sq_i_ff    <= prod_i[32:0];
      sq_q_ff    <= prod_q[32:0];
      s2_k_ff    <= s1_k_ff;
      s2_last_ff <= s1_last_ff;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // running minimum, lowest index wins a tie
   assign dist_sum = 34'(sq_i_ff) + 34'(sq_q_ff);
   assign better   = (s2_k_ff == '0) || (dist_sum < best_d_ff);

   always_ff @(posedge clock) begin
      if (s2_valid_ff && better) begin
         best_d_ff <= dist_sum;
         best_k_ff <= s2_k_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_data_ff.point_index  <= best_k_ff;
         rsp_data_ff.decided_bits <= gray_to_bin(best_k_ff) & mask_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("search pipe busy while idle");

   a_finish_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("search pipe busy at finish");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> ((best_k_ff & ~mask_ff) == '0))
      else $error("winning index outside constellation");

   a_load_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result loaded outside finish");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (issue && issue_last) |=> (state_ff == ST_DRAIN))
      else $error("issue did not stop after last point");
`endif

endmodule
